### hdl/percentile_hot_cold_classifier_assert.svh
// assertion macros shared by the hot/cold classifier rtl
`ifndef PERCENTILE_HOT_COLD_CLASSIFIER_ASSERT_SVH
`define PERCENTILE_HOT_COLD_CLASSIFIER_ASSERT_SVH
`ifndef SYNTHESIS
`define PHC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define PHC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);
`else
`define PHC_ASSERT(lbl, clk, rst_n, prop, msg)
`define PHC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### hdl/phc_pkg.sv
// shared types and constants for the hot/cold classifier
`default_nettype none
package phc_pkg;

    localparam int MAX_REGIONS = 64;
    localparam int ADDR_W      = 6;
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int HOT_W       = 32;
    localparam int NODE_W      = 6;
    localparam int PCT_W       = 14;
    localparam int K_W         = 6;
    localparam int PROD_W      = 20;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 14;

    // floor(x / 10000) == (x * RECIP_MUL) >> RECIP_SHIFT for every x below 2^PROD_W
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 34;
    localparam int QPROD_W     = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(1717987);

    localparam logic [PCT_W-1:0]  PCT_FULL      = PCT_W'(10000);
    localparam logic [PCT_W-1:0]  PCT_RESET     = PCT_W'(9000);
    localparam logic [NODE_W-1:0] HOT_TIER_RST  = NODE_W'(0);
    localparam logic [NODE_W-1:0] COLD_TIER_RST = NODE_W'(1);

    localparam logic [CFG_IDX_W-1:0] CFG_PCT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HOT  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COLD = CFG_IDX_W'(2);

    typedef struct packed {
        logic load;
        logic calc;
        logic div_step;
        logic sel_init;
        logic rd_en;
        logic acc;
        logic decide;
        logic thr_set;
        logic out_load;
        logic batch_clr;
    } t_dp_cmd;

    typedef struct packed {
        logic any_nonzero;
        logic idx_last;
        logic bit_last;
        logic rd_final;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

### hdl/phc_ctrl.sv
// sequencing state machine for load, rank, selection and result phases
`default_nettype none
`include "percentile_hot_cold_classifier_assert.svh"
module phc_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  wire               i_batch_end,
    output logic              o_stall,
    output phc_pkg::t_dp_cmd  o_cmd,
    input  phc_pkg::t_dp_sts  i_sts
);

    localparam logic [3:0] ST_LOAD       = 4'd0;
    localparam logic [3:0] ST_CALC       = 4'd1;
    localparam logic [3:0] ST_DIV        = 4'd2;
    localparam logic [3:0] ST_SEL_SCAN   = 4'd3;
    localparam logic [3:0] ST_SEL_DRAIN  = 4'd4;
    localparam logic [3:0] ST_SEL_DECIDE = 4'd5;
    localparam logic [3:0] ST_THR        = 4'd6;
    localparam logic [3:0] ST_EMIT_RD    = 4'd7;
    localparam logic [3:0] ST_EMIT_LD    = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       w_accept;

    assign o_stall  = (r_state != ST_LOAD);
    assign w_accept = i_valid && (r_state == ST_LOAD);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_LOAD: begin
                o_cmd.load = w_accept;
                if (w_accept && i_batch_end) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                o_cmd.calc = 1'b1;
                n_state = i_sts.any_nonzero ? ST_DIV : ST_THR;
            end
            ST_DIV: begin
                // rank quotient is registered into r_k in this state
                o_cmd.div_step = 1'b1;
                o_cmd.sel_init = 1'b1;
                n_state = ST_SEL_SCAN;
            end
            ST_SEL_SCAN: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.acc   = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = ST_SEL_DRAIN;
                end
            end
            ST_SEL_DRAIN: begin
                // last read of the pass lands here
                o_cmd.acc = 1'b1;
                n_state = ST_SEL_DECIDE;
            end
            ST_SEL_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = i_sts.bit_last ? ST_THR : ST_SEL_SCAN;
            end
            ST_THR: begin
                o_cmd.thr_set = 1'b1;
                n_state = ST_EMIT_RD;
            end
            ST_EMIT_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.rd_final) begin
                        o_cmd.batch_clr = 1'b1;
                        n_state = ST_LOAD;
                    end else begin
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    `PHC_ASSERT(a_sel_needs_nonzero, i_clk, i_rst_n, (r_state == ST_SEL_SCAN) |-> i_sts.any_nonzero, "selection pass on an all-silent batch")
    `PHC_ASSERT(a_load_after_final, i_clk, i_rst_n, ($past(r_state) == ST_EMIT_LD && r_state == ST_LOAD) |-> $past(i_sts.rd_final), "batch closed before its last result")
    `PHC_ASSERT(a_out_load_free, i_clk, i_rst_n, o_cmd.out_load |-> i_sts.out_free, "result loaded over a waiting result")

endmodule
`default_nettype wire

### hdl/phc_dp.sv
// datapath: config registers, region stores, rank divider, radix select, output register
`default_nettype none
`include "percentile_hot_cold_classifier_assert.svh"
module phc_dp (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [phc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [phc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire  [phc_pkg::HOT_W-1:0]        i_region_hotness,
    input  wire  [phc_pkg::NODE_W-1:0]       i_present_node,
    input  wire                              i_stall,
    input  phc_pkg::t_dp_cmd                 i_cmd,
    output phc_pkg::t_dp_sts                 o_sts,
    output logic                             o_valid,
    output logic [phc_pkg::ADDR_W-1:0]       o_region_slot,
    output logic [phc_pkg::NODE_W-1:0]       o_chosen_node,
    output logic [phc_pkg::HOT_W-1:0]        o_applied_threshold,
    output logic                             o_final_result
);

    // configuration
    logic [phc_pkg::PCT_W-1:0]  r_pct;
    logic [phc_pkg::NODE_W-1:0] r_hot_tier;
    logic [phc_pkg::NODE_W-1:0] r_cold_tier;

    // batch bookkeeping
    logic [phc_pkg::CNT_W-1:0]  r_count;
    logic                       r_any;
    logic [phc_pkg::CNT_W-1:0]  r_idx;
    logic [phc_pkg::CNT_W-1:0]  w_n_m1;
    logic                       w_wr_en;

    // region stores
    logic [phc_pkg::HOT_W-1:0]  mem_hot  [phc_pkg::MAX_REGIONS];
    logic [phc_pkg::NODE_W-1:0] mem_node [phc_pkg::MAX_REGIONS];
    logic [phc_pkg::HOT_W-1:0]  r_rd_hot;
    logic [phc_pkg::NODE_W-1:0] r_rd_node;
    logic                       r_rd_vld;
    logic [phc_pkg::ADDR_W-1:0] r_rd_slot;
    logic                       r_rd_final;

    // rank and selection
    logic [phc_pkg::PCT_W-1:0]   w_pct_sat;
    logic [phc_pkg::PROD_W-1:0]  r_prod;
    logic [phc_pkg::QPROD_W-1:0] w_quot_full;
    logic [phc_pkg::K_W-1:0]     r_k;
    logic [phc_pkg::HOT_W-1:0]   r_prefix;
    logic [phc_pkg::HOT_W-1:0]   r_hi_mask;
    logic [phc_pkg::HOT_W-1:0]   r_bit_sel;
    logic [phc_pkg::CNT_W-1:0]   r_cnt;
    logic                        w_match;
    logic                        w_take_zero;
    logic [phc_pkg::HOT_W-1:0]   r_thr;
    logic [phc_pkg::NODE_W-1:0]  w_chosen;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pct       <= phc_pkg::PCT_RESET;
            r_hot_tier  <= phc_pkg::HOT_TIER_RST;
            r_cold_tier <= phc_pkg::COLD_TIER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                phc_pkg::CFG_PCT:  r_pct       <= i_cfg_data[phc_pkg::PCT_W-1:0];
                phc_pkg::CFG_HOT:  r_hot_tier  <= i_cfg_data[phc_pkg::NODE_W-1:0];
                phc_pkg::CFG_COLD: r_cold_tier <= i_cfg_data[phc_pkg::NODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_wr_en = i_cmd.load && (r_count < phc_pkg::CNT_W'(phc_pkg::MAX_REGIONS));
    assign w_n_m1  = r_count - phc_pkg::CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_any   <= 1'b0;
        end else if (i_cmd.batch_clr) begin
            r_count <= '0;
            r_any   <= 1'b0;
        end else if (w_wr_en) begin
            r_count <= r_count + phc_pkg::CNT_W'(1);
            r_any   <= r_any || (i_region_hotness != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem_hot[r_count[phc_pkg::ADDR_W-1:0]]  <= i_region_hotness;
            mem_node[r_count[phc_pkg::ADDR_W-1:0]] <= i_present_node;
        end
        if (i_cmd.rd_en) begin
            r_rd_hot  <= mem_hot[r_idx[phc_pkg::ADDR_W-1:0]];
            r_rd_node <= mem_node[r_idx[phc_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.sel_init || i_cmd.decide || i_cmd.thr_set) begin
                r_idx <= '0;
            end else if (i_cmd.rd_en) begin
                r_idx <= r_idx + phc_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_slot  <= r_idx[phc_pkg::ADDR_W-1:0];
            r_rd_final <= (r_idx == w_n_m1);
        end
    end

    // rank = pct * (n - 1) / 10000 through a reciprocal multiply, exact for these products
    assign w_pct_sat   = (r_pct > phc_pkg::PCT_FULL) ? phc_pkg::PCT_FULL : r_pct;
    assign w_quot_full = phc_pkg::QPROD_W'(r_prod) * phc_pkg::QPROD_W'(phc_pkg::RECIP_MUL);

    // candidate matches prefix above the current bit and has a zero there
    assign w_match     = (((r_rd_hot ^ r_prefix) & r_hi_mask) == '0)
                         && ((r_rd_hot & r_bit_sel) == '0);
    assign w_take_zero = ({1'b0, r_k} < r_cnt);

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_prod <= phc_pkg::PROD_W'(w_pct_sat)
                      * phc_pkg::PROD_W'(w_n_m1[phc_pkg::K_W-1:0]);
            r_k    <= '0;
        end else if (i_cmd.div_step) begin
            r_k <= w_quot_full[phc_pkg::RECIP_SHIFT+phc_pkg::K_W-1:phc_pkg::RECIP_SHIFT];
        end else if (i_cmd.decide) begin
            if (!w_take_zero) begin
                r_k <= r_k - r_cnt[phc_pkg::K_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sel_init) begin
            r_prefix  <= '0;
            r_hi_mask <= '0;
            r_bit_sel <= {1'b1, {(phc_pkg::HOT_W-1){1'b0}}};
            r_cnt     <= '0;
        end else if (i_cmd.decide) begin
            if (!w_take_zero) begin
                r_prefix <= r_prefix | r_bit_sel;
            end
            r_hi_mask <= {1'b1, r_hi_mask[phc_pkg::HOT_W-1:1]};
            r_bit_sel <= {1'b0, r_bit_sel[phc_pkg::HOT_W-1:1]};
            r_cnt     <= '0;
        end else if (i_cmd.acc && r_rd_vld && w_match) begin
            r_cnt <= r_cnt + phc_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.thr_set) begin
            if (!r_any) begin
                r_thr <= '0;
            end else if (r_prefix == '0) begin
                r_thr <= phc_pkg::HOT_W'(1);
            end else begin
                r_thr <= r_prefix;
            end
        end
    end

    assign w_chosen = !r_any ? r_rd_node
                    : ((r_rd_hot >= r_thr) ? r_hot_tier : r_cold_tier);

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_region_slot       <= r_rd_slot;
            o_chosen_node       <= w_chosen;
            o_applied_threshold <= r_thr;
            o_final_result      <= r_rd_final;
        end
    end

    assign o_sts.any_nonzero = r_any;
    assign o_sts.idx_last    = (r_idx == w_n_m1);
    assign o_sts.bit_last    = r_bit_sel[0];
    assign o_sts.rd_final    = r_rd_final;
    assign o_sts.out_free    = !o_valid || !i_stall;

    `PHC_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= phc_pkg::CNT_W'(phc_pkg::MAX_REGIONS), "region count past capacity")
    `PHC_ASSERT(a_final_slot, i_clk, i_rst_n, (i_cmd.out_load && r_rd_final) |-> (r_rd_slot == w_n_m1[phc_pkg::ADDR_W-1:0]), "last result not on last slot")
    `PHC_ASSERT(a_result_held, i_clk, i_rst_n, (o_valid && i_stall) |=> o_valid, "stalled result dropped")

endmodule
`default_nettype wire

### hdl/percentile_hot_cold_classifier.sv
// Percentile hot/cold classifier: loads a batch of region records, then
// gives one placement result per stored region in load order.
// Input channel (i_valid / o_stall): one region per request, one per cycle
// while loading; the request with i_batch_end high closes the batch. Requests
// past 64 stored regions are dropped, but their batch_end still closes it.
// After the closing request o_stall stays high until the last result of the
// batch has been loaded into the output register.
// Output channel (o_valid / i_stall): one request per region; o_final_result
// marks the last one. A stalled result holds. Each result is read from the
// region store, then loaded into the output register. Before the first
// result a bitwise rank selection makes one pass over the region store per
// threshold bit, with one store read per cycle; it is skipped if every region
// was silent. The user must see to it that configuration
// (i_cfg_we / i_cfg_idx / i_cfg_data) is written while idle; the block does
// not enforce it. Synchronous reset clears the batch and restores percentile
// 90.00, hot node 0 and cold node 1; stored region contents are not cleared.
`default_nettype none
module percentile_hot_cold_classifier (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [phc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [phc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire  [phc_pkg::HOT_W-1:0]        i_region_hotness,
    input  wire  [phc_pkg::NODE_W-1:0]       i_present_node,
    input  wire                              i_batch_end,
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic [phc_pkg::ADDR_W-1:0]       o_region_slot,
    output logic [phc_pkg::NODE_W-1:0]       o_chosen_node,
    output logic [phc_pkg::HOT_W-1:0]        o_applied_threshold,
    output logic                             o_final_result
);

    phc_pkg::t_dp_cmd w_cmd;
    phc_pkg::t_dp_sts w_sts;

    phc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_batch_end (i_batch_end),
        .o_stall     (o_stall),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    phc_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_region_hotness    (i_region_hotness),
        .i_present_node      (i_present_node),
        .i_stall             (i_stall),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .o_valid             (o_valid),
        .o_region_slot       (o_region_slot),
        .o_chosen_node       (o_chosen_node),
        .o_applied_threshold (o_applied_threshold),
        .o_final_result      (o_final_result)
    );

endmodule
`default_nettype wire

### dv/tb_percentile_hot_cold_classifier.sv
// testbench for the percentile hot/cold classifier: batch stimulus and result checking
`timescale 1ns / 100ps

typedef struct packed {
    logic [phc_pkg::ADDR_W-1:0] slot;
    logic [phc_pkg::NODE_W-1:0] node;
    logic [phc_pkg::HOT_W-1:0]  thr;
    logic                       last;
} t_placement;

class placement_scoreboard;
    logic [phc_pkg::HOT_W-1:0]  hot_mem  [phc_pkg::MAX_REGIONS];
    logic [phc_pkg::NODE_W-1:0] node_mem [phc_pkg::MAX_REGIONS];
    int unsigned                fill;
    bit                         any_hot;
    logic [phc_pkg::PCT_W-1:0]  pct_reg;
    logic [phc_pkg::NODE_W-1:0] hot_tier_reg;
    logic [phc_pkg::NODE_W-1:0] cold_tier_reg;
    t_placement                 placements_q[$];
    int                         fails;
    int                         reported;

    function new();
        fill          = 0;
        any_hot       = 0;
        pct_reg       = phc_pkg::PCT_RESET;
        hot_tier_reg  = phc_pkg::HOT_TIER_RST;
        cold_tier_reg = phc_pkg::COLD_TIER_RST;
        fails         = 0;
        reported      = 0;
    endfunction

    function void set_reg(logic [phc_pkg::CFG_IDX_W-1:0] idx,
                          logic [phc_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            phc_pkg::CFG_PCT:  pct_reg       = data[phc_pkg::PCT_W-1:0];
            phc_pkg::CFG_HOT:  hot_tier_reg  = data[phc_pkg::NODE_W-1:0];
            phc_pkg::CFG_COLD: cold_tier_reg = data[phc_pkg::NODE_W-1:0];
            default: ;
        endcase
    endfunction

    function void record_fail(string msg);
        fails++;
        if (reported < 10) begin
            reported++;
            $display("%s", msg);
        end
    endfunction

    // accepted request: store it, and on batch end predict the whole batch
    function void note_request(logic [phc_pkg::HOT_W-1:0] hot,
                               logic [phc_pkg::NODE_W-1:0] node, logic batch_end);
        t_placement                p;
        int unsigned               n, k, pc, lt, le, i, j;
        bit                        found;
        logic [phc_pkg::HOT_W-1:0] thr;
        if (fill < phc_pkg::MAX_REGIONS) begin
            hot_mem[fill]  = hot;
            node_mem[fill] = node;
            fill++;
            if (hot != 0) any_hot = 1;
        end
        if (!batch_end) return;
        n   = fill;
        thr = '0;
        if (any_hot) begin
            pc = 32'((pct_reg > phc_pkg::PCT_FULL) ? phc_pkg::PCT_FULL : pct_reg);
            k  = (pc * (n - 1)) / 32'(phc_pkg::PCT_FULL);
            found = 0;
            // k-th smallest: value with fewer than k+1 below it and at least k+1 at or below
            for (i = 0; i < n; i++) begin
                lt = 0;
                le = 0;
                for (j = 0; j < n; j++) begin
                    if (hot_mem[j] < hot_mem[i]) lt++;
                    if (hot_mem[j] <= hot_mem[i]) le++;
                end
                if (!found && lt <= k && k < le) begin
                    thr   = hot_mem[i];
                    found = 1;
                end
            end
            if (thr == 0) thr = 1;
        end
        for (i = 0; i < n; i++) begin
            p.slot = i[phc_pkg::ADDR_W-1:0];
            if (!any_hot) p.node = node_mem[i];
            else p.node = (hot_mem[i] >= thr) ? hot_tier_reg : cold_tier_reg;
            p.thr  = thr;
            p.last = (i + 1 == n);
            placements_q = {placements_q, p};
        end
        fill    = 0;
        any_hot = 0;
    endfunction

    function void check_result(t_placement got);
        t_placement want;
        if (placements_q.size() == 0) begin
            record_fail($sformatf("unexpected result: slot %0d node %0d thr %0d final %0b",
                                  got.slot, got.node, got.thr, got.last));
        end else begin
            want = placements_q.pop_front();
            if (want !== got)
                record_fail($sformatf({"mismatch: expected slot %0d node %0d thr %0d final %0b,",
                                       " got slot %0d node %0d thr %0d final %0b"},
                                      want.slot, want.node, want.thr, want.last,
                                      got.slot, got.node, got.thr, got.last));
        end
    endfunction

    function int pending();
        return placements_q.size();
    endfunction
endclass

module tb_percentile_hot_cold_classifier;
    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [phc_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [phc_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           i_valid;
    logic                           o_stall;
    logic [phc_pkg::HOT_W-1:0]      i_region_hotness;
    logic [phc_pkg::NODE_W-1:0]     i_present_node;
    logic                           i_batch_end;
    logic                           o_valid;
    logic                           i_stall;
    logic [phc_pkg::ADDR_W-1:0]     o_region_slot;
    logic [phc_pkg::NODE_W-1:0]     o_chosen_node;
    logic [phc_pkg::HOT_W-1:0]      o_applied_threshold;
    logic                           o_final_result;

    placement_scoreboard sb;
    bit                  idle_on;
    int                  rx_hold_cycles;
    int                  requests_sent;

    percentile_hot_cold_classifier DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_region_hotness    (i_region_hotness),
        .i_present_node      (i_present_node),
        .i_batch_end         (i_batch_end),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_region_slot       (o_region_slot),
        .o_chosen_node       (o_chosen_node),
        .o_applied_threshold (o_applied_threshold),
        .o_final_result      (o_final_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("tb_percentile_hot_cold_classifier failed");
        $finish;
    end

    task automatic send_region(input logic [phc_pkg::HOT_W-1:0] hot,
                               input logic [phc_pkg::NODE_W-1:0] node,
                               input logic batch_end);
        int gap;
        gap = idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_region_hotness <= hot;
        i_present_node   <= node;
        i_batch_end      <= batch_end;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(hot, node, batch_end);
        requests_sent++;
    endtask

    // all three registers, back to back, then the enable drops
    task automatic write_config(input logic [phc_pkg::PCT_W-1:0] pct,
                                input logic [phc_pkg::NODE_W-1:0] hot_tier,
                                input logic [phc_pkg::NODE_W-1:0] cold_tier);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= phc_pkg::CFG_PCT;
        i_cfg_data <= phc_pkg::CFG_DATA_W'(pct);
        @(posedge i_clk);
        sb.set_reg(phc_pkg::CFG_PCT, phc_pkg::CFG_DATA_W'(pct));
        i_cfg_idx  <= phc_pkg::CFG_HOT;
        i_cfg_data <= phc_pkg::CFG_DATA_W'(hot_tier);
        @(posedge i_clk);
        sb.set_reg(phc_pkg::CFG_HOT, phc_pkg::CFG_DATA_W'(hot_tier));
        i_cfg_idx  <= phc_pkg::CFG_COLD;
        i_cfg_data <= phc_pkg::CFG_DATA_W'(cold_tier);
        @(posedge i_clk);
        sb.set_reg(phc_pkg::CFG_COLD, phc_pkg::CFG_DATA_W'(cold_tier));
        i_cfg_we   <= 1'b0;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic run_batch(input int len);
        logic [phc_pkg::HOT_W-1:0] pool [4];
        logic [phc_pkg::HOT_W-1:0] hot;
        bit                        silent;
        int                        mode, i;
        silent = ($urandom_range(0, 11) == 0);
        for (i = 0; i < 4; i++) pool[i] = $urandom;
        for (i = 0; i < len; i++) begin
            mode = $urandom_range(0, 19);
            if (silent || mode < 4) hot = '0;
            else if (mode < 8)      hot = $urandom_range(1, 8);
            else if (mode < 11)     hot = pool[$urandom_range(0, 3)];
            else if (mode < 13)     hot = '1;
            else                    hot = $urandom;
            send_region(hot, phc_pkg::NODE_W'($urandom_range(0, 63)), i == len - 1);
        end
    endtask

    // result side: random stall before each request while idle_on is set, long hold when asked
    initial begin
        int         wait_cycles;
        t_placement got;
        i_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            wait_cycles = idle_on ? $urandom_range(0, 14) : 0;
            if (rx_hold_cycles != 0) begin
                wait_cycles    = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (wait_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            got = {o_region_slot, o_chosen_node, o_applied_threshold, o_final_result};
            sb.check_result(got);
        end
    end

    initial begin
        int phase, batch_no, nb, b, len, pick;
        logic [phc_pkg::PCT_W-1:0] pct;
        sb             = new();
        idle_on        = 1'b1;
        rx_hold_cycles = 0;
        requests_sent  = 0;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= phc_pkg::CFG_PCT;
        i_cfg_data       <= '0;
        i_valid          <= 1'b0;
        i_region_hotness <= '0;
        i_present_node   <= '0;
        i_batch_end      <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: single region, silent batch, hotness extremes
        send_region('1, 6'd63, 1'b1);
        send_region('0, 6'd0, 1'b0);
        send_region('0, 6'd63, 1'b0);
        send_region('0, 6'd21, 1'b1);
        send_region('0, 6'd5, 1'b0);
        send_region(32'd1, 6'd6, 1'b0);
        send_region(32'h8000_0000, 6'd7, 1'b0);
        send_region('1, 6'd8, 1'b1);
        drain_results();
        // percentile zero picks the lowest rank; in the first batch it lands on a zero, so the threshold floors to one
        write_config(14'd0, 6'd63, 6'd0);
        send_region('0, 6'd1, 1'b0);
        send_region('0, 6'd2, 1'b0);
        send_region(32'd3, 6'd3, 1'b1);
        send_region(32'd5, 6'd10, 1'b0);
        send_region(32'd7, 6'd11, 1'b0);
        send_region(32'd5, 6'd12, 1'b1);
        drain_results();
        // percentile above full scale saturates to the top rank
        write_config(14'd16383, 6'd42, 6'd21);
        send_region(32'd10, 6'd1, 1'b0);
        send_region(32'd20, 6'd2, 1'b0);
        send_region(32'd30, 6'd3, 1'b0);
        send_region(32'd20, 6'd4, 1'b1);
        drain_results();
        write_config(14'd10000, 6'd0, 6'd63);
        send_region(32'd9, 6'd30, 1'b0);
        send_region(32'd9, 6'd31, 1'b0);
        send_region(32'd2, 6'd32, 1'b1);
        drain_results();

        phase    = 0;
        batch_no = 0;
        while (requests_sent < 255) begin
            pick = $urandom_range(0, 5);
            case (pick)
                0:       pct = '0;
                1:       pct = phc_pkg::PCT_FULL;
                2:       pct = phc_pkg::PCT_W'($urandom_range(10001, 16383));
                3:       pct = phc_pkg::PCT_RESET;
                default: pct = phc_pkg::PCT_W'($urandom_range(0, 10000));
            endcase
            write_config(pct, phc_pkg::NODE_W'($urandom_range(0, 63)),
                         phc_pkg::NODE_W'($urandom_range(0, 63)));
            idle_on = ($urandom_range(0, 3) != 0);
            if (phase == 2) begin
                // results back up while the sender keeps offering requests
                idle_on        = 1'b0;
                rx_hold_cycles = 400;
            end
            nb = $urandom_range(3, 5);
            for (b = 0; b < nb; b++) begin
                pick = $urandom_range(0, 19);
                if (batch_no == 3)      len = $urandom_range(65, 72);
                else if (batch_no == 8) len = phc_pkg::MAX_REGIONS;
                else if (pick < 14)     len = $urandom_range(1, 12);
                else                    len = $urandom_range(13, 40);
                run_batch(len);
                batch_no++;
            end
            drain_results();
            phase++;
        end

        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("tb_percentile_hot_cold_classifier passed");
        end else begin
            $display("tb_percentile_hot_cold_classifier failed");
        end
        $finish;
    end
endmodule
